// ----- sv/ybmp_pkg.sv -----
// Shared types, constants and helper functions for the YUYV to BMP stream encoder.
// Used by ybmp_front, ybmp_queue, ybmp_back and yuyv_to_bmp_stream; no dependencies.
package ybmp_pkg;

	localparam logic [12:0] DIM_MAX      = 13'd4096;
	localparam logic [12:0] WIDTH_RESET  = 13'd256;
	localparam logic [12:0] HEIGHT_RESET = 13'd64;
	localparam logic [12:0] WIDTH_MIN    = 13'd2;
	localparam logic [12:0] HEIGHT_MIN   = 13'd1;

	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [26:0] HEADER_BYTES = 27'd54;
	localparam logic [5:0]  HDR_LAST_IDX = 6'd53;
	localparam logic [5:0]  PIX_LAST_IDX = 6'd5;

	localparam logic signed [17:0] COEF_Y  = 18'sd298;
	localparam logic signed [17:0] COEF_BU = 18'sd516;
	localparam logic signed [17:0] COEF_GU = 18'sd100;
	localparam logic signed [17:0] COEF_GV = 18'sd208;
	localparam logic signed [17:0] COEF_RV = 18'sd409;
	localparam logic signed [19:0] ROUND   = 20'sd128;

	typedef struct packed {
		logic            hdr;
		logic            last;
		logic [1:0]      pad;
		logic [12:0]     width;
		logic [12:0]     height;
		logic [26:0]     fsize;
		logic [5:0][7:0] pix;
	} ybmp_entry_t;

	function automatic logic [7:0] clamp8(input logic signed [19:0] s);
		logic [7:0] r;
		if (s[19]) begin
			r = 8'd0;
		end else if (|s[18:16]) begin
			r = 8'd255;
		end else begin
			r = s[15:8];
		end
		return r;
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input logic [12:0] width,
		input logic [12:0] height, input logic [26:0] fsize);
		logic [31:0] fs;
		logic [31:0] w32;
		logic [31:0] nh;
		logic [7:0]  r;
		fs  = {5'd0, fsize};
		w32 = {19'd0, width};
		nh  = 32'd0 - {19'd0, height};
		case (idx)
			6'd0:  r = 8'h42;
			6'd1:  r = 8'h4D;
			6'd2:  r = fs[7:0];
			6'd3:  r = fs[15:8];
			6'd4:  r = fs[23:16];
			6'd5:  r = fs[31:24];
			6'd10: r = 8'd54;
			6'd14: r = 8'd40;
			6'd18: r = w32[7:0];
			6'd19: r = w32[15:8];
			6'd20: r = w32[23:16];
			6'd21: r = w32[31:24];
			6'd22: r = nh[7:0];
			6'd23: r = nh[15:8];
			6'd24: r = nh[23:16];
			6'd25: r = nh[31:24];
			6'd26: r = 8'd1;
			6'd28: r = 8'd24;
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/ybmp_front.sv -----
// Front end: configuration registers, frame position counters and colour products.
// Accepts macropixels, classifies them and pushes complete entries; uses ybmp_pkg.
module ybmp_front import ybmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  luma_first,
	input  logic [7:0]  chroma_blue,
	input  logic [7:0]  luma_second,
	input  logic [7:0]  chroma_red,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output logic        push,
	output ybmp_entry_t push_entry,
	input  logic        q_full
);

	logic [12:0] width_q, height_q;
	logic [11:0] col_q, row_q;
	logic [12:0] wc, eff_w, eff_h;
	logic [11:0] pairs;
	logic        row_end, frame_last, accept;
	logic [1:0]  pad;
	logic [13:0] row_bytes;
	logic [26:0] area;
	logic signed [9:0] c0, c1, d, e;

	logic               valid_s1, hdr_s1, last_s1;
	logic [1:0]         pad_s1;
	logic [12:0]        w_s1, h_s1;
	logic [26:0]        fsize_s1;
	logic signed [17:0] py0_s1, py1_s1, pbu_s1, pgu_s1, pgv_s1, prv_s1;
	logic signed [19:0] b0, g0, r0, b1, g1, r1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < WIDTH_MIN) begin
			wc = WIDTH_MIN;
		end else if (width_q > DIM_MAX) begin
			wc = DIM_MAX;
		end else begin
			wc = width_q;
		end
		eff_w = {wc[12:1], 1'b0};
		if (height_q < HEIGHT_MIN) begin
			eff_h = HEIGHT_MIN;
		end else if (height_q > DIM_MAX) begin
			eff_h = DIM_MAX;
		end else begin
			eff_h = height_q;
		end
	end

	assign pairs      = eff_w[12:1];
	assign row_end    = ({1'b0, col_q} + 13'd1) >= {1'b0, pairs};
	assign frame_last = row_end && (({1'b0, row_q} + 13'd1) >= eff_h);
	assign pad        = eff_w[1] ? 2'd2 : 2'd0;
	assign row_bytes  = 14'({eff_w, 1'b0}) + 14'(eff_w) + 14'(pad);
	assign area       = 27'(row_bytes) * 27'(eff_h);

	assign c0 = $signed({2'b00, luma_first})  - 10'sd16;
	assign c1 = $signed({2'b00, luma_second}) - 10'sd16;
	assign d  = $signed({2'b00, chroma_blue}) - 10'sd128;
	assign e  = $signed({2'b00, chroma_red})  - 10'sd128;

	assign push     = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_last ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_s1   <= (col_q == 12'd0) && (row_q == 12'd0);
			last_s1  <= frame_last;
			pad_s1   <= row_end ? pad : 2'd0;
			w_s1     <= eff_w;
			h_s1     <= eff_h;
			fsize_s1 <= area + HEADER_BYTES;
			py0_s1   <= 18'(COEF_Y * c0);
			py1_s1   <= 18'(COEF_Y * c1);
			pbu_s1   <= 18'(COEF_BU * d);
			pgu_s1   <= 18'(COEF_GU * d);
			pgv_s1   <= 18'(COEF_GV * e);
			prv_s1   <= 18'(COEF_RV * e);
		end
	end

	assign b0 = 20'(py0_s1) + 20'(pbu_s1) + ROUND;
	assign g0 = 20'(py0_s1) - 20'(pgu_s1) - 20'(pgv_s1) + ROUND;
	assign r0 = 20'(py0_s1) + 20'(prv_s1) + ROUND;
	assign b1 = 20'(py1_s1) + 20'(pbu_s1) + ROUND;
	assign g1 = 20'(py1_s1) - 20'(pgu_s1) - 20'(pgv_s1) + ROUND;
	assign r1 = 20'(py1_s1) + 20'(prv_s1) + ROUND;

	always_comb begin
		push_entry.hdr    = hdr_s1;
		push_entry.last   = last_s1;
		push_entry.pad    = pad_s1;
		push_entry.width  = w_s1;
		push_entry.height = h_s1;
		push_entry.fsize  = fsize_s1;
		push_entry.pix[0] = clamp8(b0);
		push_entry.pix[1] = clamp8(g0);
		push_entry.pix[2] = clamp8(r0);
		push_entry.pix[3] = clamp8(b1);
		push_entry.pix[4] = clamp8(g1);
		push_entry.pix[5] = clamp8(r1);
	end

endmodule

// ----- sv/ybmp_queue.sv -----
// Two-entry queue of classified macropixels between the front and back ends.
// Uses ybmp_pkg for the entry type.
module ybmp_queue import ybmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ybmp_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output ybmp_entry_t head,
	output logic        head_valid
);

	ybmp_entry_t entry_q [2];
	logic [1:0]  count_q;
	logic        wr_ptr_q, rd_ptr_q;

	assign full       = count_q == 2'd2;
	assign head_valid = count_q != 2'd0;
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !head_valid))
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("queue count out of range");

endmodule

// ----- sv/ybmp_back.sv -----
// Back end: byte sequencer that turns queued entries into header, pixel and padding beats.
// Holds the output register; uses ybmp_pkg.
module ybmp_back import ybmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ybmp_entry_t head,
	input  logic        head_valid,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_end
);

	typedef enum logic [3:0] {
		ST_NEW = 4'b0001,
		ST_HDR = 4'b0010,
		ST_PIX = 4'b0100,
		ST_PAD = 4'b1000
	} ybmp_phase_t;

	ybmp_phase_t phase_q, cur_phase, next_phase;
	logic [5:0]  idx_q, next_idx, pad_last;
	logic        advance, byte_end, entry_done;
	logic [7:0]  byte_val;
	logic        out_valid_q, frame_end_q;
	logic [7:0]  out_byte_q;

	assign advance  = head_valid && (!out_valid_q || !out_stall);
	assign pad_last = 6'(head.pad) - 6'd1;

	always_comb begin
		if (phase_q == ST_NEW) begin
			cur_phase = head.hdr ? ST_HDR : ST_PIX;
		end else begin
			cur_phase = phase_q;
		end
		byte_val   = 8'd0;
		byte_end   = 1'b0;
		entry_done = 1'b0;
		next_phase = cur_phase;
		next_idx   = idx_q + 6'd1;
		case (cur_phase)
			ST_HDR: begin
				byte_val = hdr_byte(idx_q, head.width, head.height, head.fsize);
				if (idx_q == HDR_LAST_IDX) begin
					next_phase = ST_PIX;
					next_idx   = 6'd0;
				end
			end
			ST_PIX: begin
				byte_val = head.pix[idx_q[2:0]];
				if (idx_q == PIX_LAST_IDX) begin
					next_idx = 6'd0;
					if (head.pad == 2'd0) begin
						byte_end   = head.last;
						entry_done = 1'b1;
						next_phase = ST_NEW;
					end else begin
						next_phase = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (idx_q == pad_last) begin
					byte_end   = head.last;
					entry_done = 1'b1;
					next_phase = ST_NEW;
					next_idx   = 6'd0;
				end
			end
			default: begin
				next_phase = ST_NEW;
				next_idx   = 6'd0;
			end
		endcase
	end

	assign pop = advance && entry_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ST_NEW;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			frame_end_q <= 1'b0;
		end else if (advance) begin
			phase_q     <= next_phase;
			idx_q       <= next_idx;
			out_valid_q <= 1'b1;
			frame_end_q <= byte_end;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
			frame_end_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_val;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;

	a_new_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ST_NEW |-> idx_q == 6'd0)
		else $error("sequencer index not cleared between entries");
	a_end_valid: assert property (@(posedge clk) disable iff (!arst_n)
		frame_end_q |-> out_valid_q)
		else $error("frame end flagged without a beat");

endmodule

// ----- sv/yuyv_to_bmp_stream.sv -----
// A macropixel passes the front stage register, the queue and the output register.
// Throughput: one byte beat per cycle while fed and not stalled; 6 beats per macropixel,
// plus 2 padding beats at a row end when the width is not a multiple of 4, plus 54
// header beats per frame. The byte sequencer in the back end sets the rate; a two-entry
// queue decouples it. Reset (asynchronous, active low) clears counters, queue and output
// valid, and sets the frame size to 256 x 64.
module yuyv_to_bmp_stream import ybmp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  luma_first,
	input  logic [7:0]  chroma_blue,
	input  logic [7:0]  luma_second,
	input  logic [7:0]  chroma_red,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        frame_end,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	logic        push, q_full, pop, head_valid;
	ybmp_entry_t push_entry, head;

	ybmp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.luma_first  (luma_first),
		.chroma_blue (chroma_blue),
		.luma_second (luma_second),
		.chroma_red  (chroma_red),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.push_entry  (push_entry),
		.q_full      (q_full)
	);

	ybmp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	ybmp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.frame_end  (frame_end)
	);

endmodule

// ----- test/yuyv_to_bmp_stream_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for yuyv_to_bmp_stream: drives macropixels and frame sizes,
// predicts the BMP byte stream in a small scoreboard class and checks every output beat.
// Depends on ybmp_pkg and the yuyv_to_bmp_stream RTL only.
module yuyv_to_bmp_stream_test;
	import ybmp_pkg::*;

	localparam int unsigned BMP_HEADER_LEN = 54;
	localparam int unsigned BMP_DIB_LEN    = 40;
	localparam int unsigned BMP_BPP        = 24;
	localparam logic [7:0]  BMP_TAG_B      = "B";
	localparam logic [7:0]  BMP_TAG_M      = "M";
	localparam int          SETTLE_CYCLES  = 16;
	localparam int          CYCLE_LIMIT    = 1000000;
	localparam int          RANDOM_PHASES  = 12;

	class bmp_stream_checker;
		logic [12:0]  width_reg;
		logic [12:0]  height_reg;
		int unsigned  column_idx;
		int unsigned  row_idx;
		logic [8:0]   expected_bytes[$];
		int           mismatches;
		int           items_seen;
		int           bytes_seen;
		int           frames_seen;

		function new();
			width_reg   = WIDTH_RESET;
			height_reg  = HEIGHT_RESET;
			column_idx  = 0;
			row_idx     = 0;
			mismatches  = 0;
			items_seen  = 0;
			bytes_seen  = 0;
			frames_seen = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [12:0] value);
			if (idx == REG_FRAME_WIDTH) begin
				width_reg = value;
			end else if (idx == REG_FRAME_HEIGHT) begin
				height_reg = value;
			end
		endfunction

		function logic [7:0] clip_channel(int sum);
			if (sum < 0) begin
				return 8'd0;
			end
			if ((sum >>> 8) > 255) begin
				return 8'd255;
			end
			return 8'(sum >>> 8);
		endfunction

		function void push(logic [7:0] value, logic end_flag);
			expected_bytes.push_back({end_flag, value});
		endfunction

		function void push_le(int unsigned value, int count);
			for (int i = 0; i < count; i++) begin
				push(value[8*i +: 8], 1'b0);
			end
		endfunction

		function void push_pixel(logic [7:0] luma, int cb, int cr, logic end_flag);
			int c;
			c = luma;
			c = c - 16;
			push(clip_channel(298 * c + 516 * cb + 128), 1'b0);
			push(clip_channel(298 * c - 100 * cb - 208 * cr + 128), 1'b0);
			push(clip_channel(298 * c + 409 * cr + 128), end_flag);
		endfunction

		function void add_macropixel(logic [7:0] y0, logic [7:0] cb_raw, logic [7:0] y1,
			logic [7:0] cr_raw);
			int unsigned w;
			int unsigned h;
			int unsigned row_bytes;
			int unsigned pad;
			int unsigned pairs;
			int unsigned stream_len;
			int          cb;
			int          cr;
			logic        row_end;
			logic        frame_last;
			w = width_reg;
			if (w < WIDTH_MIN) begin
				w = WIDTH_MIN;
			end
			if (w > DIM_MAX) begin
				w = DIM_MAX;
			end
			w = w & ~32'd1;
			h = height_reg;
			if (h < HEIGHT_MIN) begin
				h = HEIGHT_MIN;
			end
			if (h > DIM_MAX) begin
				h = DIM_MAX;
			end
			row_bytes  = ((w * 3 + 3) / 4) * 4;
			pad        = row_bytes - w * 3;
			pairs      = w / 2;
			cb         = cb_raw;
			cb         = cb - 128;
			cr         = cr_raw;
			cr         = cr - 128;
			row_end    = (column_idx + 1 >= pairs);
			frame_last = row_end && (row_idx + 1 >= h);
			if (column_idx == 0 && row_idx == 0) begin
				stream_len = BMP_HEADER_LEN + row_bytes * h;
				push(BMP_TAG_B, 1'b0);
				push(BMP_TAG_M, 1'b0);
				push_le(stream_len, 4);
				push_le(0, 4);
				push_le(BMP_HEADER_LEN, 4);
				push_le(BMP_DIB_LEN, 4);
				push_le(w, 4);
				push_le(32'd0 - h, 4);
				push_le(1, 2);
				push_le(BMP_BPP, 2);
				for (int i = 0; i < 24; i++) begin
					push(8'd0, 1'b0);
				end
			end
			push_pixel(y0, cb, cr, 1'b0);
			push_pixel(y1, cb, cr, frame_last && pad == 0);
			if (row_end) begin
				for (int i = 0; i < pad; i++) begin
					push(8'd0, frame_last && (i + 1 == pad));
				end
				column_idx = 0;
				row_idx    = frame_last ? 0 : ((row_idx + 1) & 32'hFFF);
			end else begin
				column_idx = (column_idx + 1) & 32'hFFF;
			end
			items_seen++;
		endfunction

		function void check_byte(logic [7:0] value, logic end_flag);
			logic [8:0] want;
			bytes_seen++;
			if (end_flag === 1'b1) begin
				frames_seen++;
			end
			if (expected_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, out_byte %02h frame_end %0b", $time, value,
					end_flag);
				return;
			end
			want = expected_bytes.pop_front();
			if (value !== want[7:0]) begin
				mismatches++;
				$display("%0t: out_byte expected %02h actual %02h", $time, want[7:0], value);
			end
			if (end_flag !== want[8]) begin
				mismatches++;
				$display("%0t: frame_end expected %0b actual %0b", $time, want[8], end_flag);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  luma_first;
	logic [7:0]  chroma_blue;
	logic [7:0]  luma_second;
	logic [7:0]  chroma_red;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        frame_end;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [12:0] cfg_data;

	bmp_stream_checker sb = new();
	logic [31:0]       directed_items[$];
	int                send_idle_pct = 0;
	int                stall_pct = 0;
	int                cycle_count = 0;
	int                size_settings = 0;

	yuyv_to_bmp_stream u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.luma_first (luma_first),
		.chroma_blue(chroma_blue),
		.luma_second(luma_second),
		.chroma_red (chroma_red),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.frame_end  (frame_end),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_byte(out_byte, frame_end);
		end
	end

	function automatic logic [7:0] pick_sample();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Directed macropixels are taken first; once they run out the content is random.
	task automatic send_pixels(int count);
		int          sent;
		logic [31:0] item;
		sent = 0;
		while (sent < count) begin
			@(negedge clk);
			if ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
			end else begin
				if (directed_items.size() != 0) begin
					item = directed_items.pop_front();
				end else begin
					item = {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
				end
				in_valid    <= 1'b1;
				luma_first  <= item[31:24];
				chroma_blue <= item[23:16];
				luma_second <= item[15:8];
				chroma_red  <= item[7:0];
				do begin
					@(posedge clk);
				end while (in_stall);
				sb.add_macropixel(luma_first, chroma_blue, luma_second, chroma_red);
				sent++;
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		while (sb.expected_bytes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [12:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Sizes change only once the stream has drained and the pipeline has settled.
	task automatic set_size(logic [12:0] w, logic [12:0] h);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		size_settings++;
	endtask

	task automatic run_random_phase(int phase);
		logic [12:0] w;
		logic [12:0] h;
		int          count;
		case ($urandom_range(9))
			0: w = 13'd0;
			1: w = 13'd1;
			2: w = 13'd8191;
			3: w = 13'($urandom_range(15) * 2 + 3);
			default: w = 13'($urandom_range(12) * 2);
		endcase
		case ($urandom_range(7))
			0: h = 13'd0;
			1: h = 13'd8191;
			default: h = 13'($urandom_range(4, 1));
		endcase
		set_size(w, h);
		case (phase % 4)
			0: begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			1: begin
				send_idle_pct = 57;
				stall_pct     = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct     = 57;
			end
			default: begin
				send_idle_pct = 17;
				stall_pct     = 17;
			end
		endcase
		count = $urandom_range(30, 20);
		send_pixels(count / 2);
		// Now and then the source holds off until the whole stream so far is out.
		if (phase == 1 || phase == 6) begin
			wait_drain();
		end
		send_pixels(count - count / 2);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		luma_first  = 8'd0;
		chroma_blue = 8'd0;
		luma_second = 8'd0;
		chroma_red  = 8'd0;
		out_stall   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_FRAME_WIDTH;
		cfg_data    = 13'd0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset size first, then single-pair frames through the colour extremes.
		directed_items.push_back({8'd16, 8'd128, 8'd235, 8'd128});
		send_pixels(1);
		set_size(13'd2, 13'd1);
		directed_items.push_back({8'd0, 8'd0, 8'd0, 8'd0});
		directed_items.push_back({8'd255, 8'd255, 8'd255, 8'd255});
		directed_items.push_back({8'd0, 8'd255, 8'd255, 8'd0});
		directed_items.push_back({8'd255, 8'd0, 8'd0, 8'd255});
		directed_items.push_back({8'd16, 8'd128, 8'd235, 8'd128});
		directed_items.push_back({8'd235, 8'd16, 8'd81, 8'd240});
		directed_items.push_back({8'd128, 8'd128, 8'd128, 8'd128});
		directed_items.push_back({8'd255, 8'd255, 8'd0, 8'd0});
		send_pixels(8);
		// Sizes below the minimum, odd, at the maximum and beyond it.
		set_size(13'd0, 13'd0);
		send_pixels(2);
		set_size(13'd1, 13'd1);
		send_pixels(1);
		set_size(13'd8191, 13'd8191);
		send_pixels(2);
		set_size(13'd4096, 13'd4096);
		send_pixels(1);
		set_size(13'd5, 13'd2);
		send_pixels(4);
		set_size(13'd6, 13'd1);
		send_pixels(3);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			run_random_phase(p);
		end

		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d macropixels under %0d frame sizes; checked %0d beats, %0d frame ends.",
			sb.items_seen, size_settings, sb.bytes_seen, sb.frames_seen);
		if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
sv/ybmp_pkg.sv
sv/ybmp_front.sv
sv/ybmp_queue.sv
sv/ybmp_back.sv
sv/yuyv_to_bmp_stream.sv
test/yuyv_to_bmp_stream_test.sv
